[rtl/core/assert_macros.svh]
// assertion macros used by rdq_checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is held low
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("assertion failed");

// next-cycle implication, disabled while reset is held low
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

[rtl/core/rdq_pkg.sv]
// shared types, codes and default sizes for the reversible deque
// no dependencies
package rdq_pkg;

    localparam int DEPTH_DEF = 1024;
    localparam int DATA_W    = 8;
    localparam int OP_W      = 2;
    localparam int STAT_W    = 2;
    localparam int FILL_W    = 11;

    typedef enum logic [OP_W-1:0] {
        OP_TOGGLE     = 2'd0,
        OP_PUSH_FRONT = 2'd1,
        OP_PUSH_BACK  = 2'd2,
        OP_POP        = 2'd3
    } t_opcode;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic exec;
        logic capture;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic full;
    } t_dp_status;

endpackage

[rtl/core/rdq_ram.sv]
// generic single-write, single-read ram with registered read data
// no dependencies
module rdq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/rdq_datapath.sv]
// pointers, occupancy, reverse flag, character ram and result registers
// depends on rdq_pkg and rdq_ram
module rdq_datapath #(
    parameter int DEPTH = rdq_pkg::DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  rdq_pkg::t_cmd               i_cmd,
    input  logic [rdq_pkg::OP_W-1:0]    i_opcode,
    input  logic [rdq_pkg::DATA_W-1:0]  i_data_byte,
    output rdq_pkg::t_dp_status         o_dp_status,
    output logic [rdq_pkg::DATA_W-1:0]  o_out_byte,
    output logic [rdq_pkg::STAT_W-1:0]  o_status,
    output logic [rdq_pkg::FILL_W-1:0]  o_fill_count
);

    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int SW    = CW + 1;
    localparam int EXT_W = CW + rdq_pkg::FILL_W;

    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_occ, n_occ;
    logic          r_rev, n_rev;

    logic [rdq_pkg::DATA_W-1:0] r_out_byte;
    rdq_pkg::t_status           r_status, n_status;
    logic [rdq_pkg::FILL_W-1:0] r_fill;

    rdq_pkg::t_opcode op;
    logic             full, empty, at_front;
    logic [AW-1:0]    head_dec, head_inc, back_waddr, back_raddr;
    logic [SW-1:0]    sum_push, sum_pop;
    logic [EXT_W-1:0] fill_ext;

    logic                       ram_we, ram_re;
    logic [AW-1:0]              ram_waddr, ram_raddr;
    logic [rdq_pkg::DATA_W-1:0] ram_rdata;

    assign op    = rdq_pkg::t_opcode'(i_opcode);
    assign full  = (r_occ == CW'(DEPTH));
    assign empty = (r_occ == '0);

    assign head_dec = (r_head == '0) ? AW'(DEPTH - 1) : r_head - AW'(1);
    assign head_inc = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + AW'(1);

    assign sum_push   = SW'(r_head) + SW'(r_occ);
    assign sum_pop    = SW'(r_head) + SW'(r_occ) - SW'(1);
    assign back_waddr = (sum_push >= SW'(DEPTH)) ? AW'(sum_push - SW'(DEPTH)) : AW'(sum_push);
    assign back_raddr = (sum_pop >= SW'(DEPTH)) ? AW'(sum_pop - SW'(DEPTH)) : AW'(sum_pop);

    always_comb begin
        n_head    = r_head;
        n_occ     = r_occ;
        n_rev     = r_rev;
        n_status  = rdq_pkg::ST_OK;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_waddr = back_waddr;
        ram_raddr = r_head;
        at_front  = 1'b0;
        if (i_cmd.exec) begin
            unique case (op)
                rdq_pkg::OP_TOGGLE: begin
                    n_rev = ~r_rev;
                end
                rdq_pkg::OP_PUSH_FRONT, rdq_pkg::OP_PUSH_BACK: begin
                    at_front = (op == rdq_pkg::OP_PUSH_FRONT) ^ r_rev;
                    if (full) begin
                        n_status = rdq_pkg::ST_FULL;
                    end else begin
                        ram_we = 1'b1;
                        n_occ  = r_occ + CW'(1);
                        if (at_front) begin
                            n_head    = head_dec;
                            ram_waddr = head_dec;
                        end
                    end
                end
                rdq_pkg::OP_POP: begin
                    at_front = ~r_rev;
                    if (empty) begin
                        n_status = rdq_pkg::ST_EMPTY;
                    end else begin
                        ram_re = 1'b1;
                        n_occ  = r_occ - CW'(1);
                        if (at_front) begin
                            n_head = head_inc;
                        end else begin
                            ram_raddr = back_raddr;
                        end
                    end
                end
                default: begin
                    n_status = rdq_pkg::ST_OK;
                end
            endcase
        end
    end

    assign fill_ext = EXT_W'(n_occ);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_occ  <= '0;
            r_rev  <= 1'b0;
        end else begin
            r_head <= n_head;
            r_occ  <= n_occ;
            r_rev  <= n_rev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_out_byte <= '0;
            r_status   <= n_status;
            r_fill     <= fill_ext[rdq_pkg::FILL_W-1:0];
        end else if (i_cmd.capture) begin
            r_out_byte <= ram_rdata;
        end
    end

    rdq_ram #(
        .WIDTH (rdq_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_data_byte),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_dp_status.empty = empty;
    assign o_dp_status.full  = full;
    assign o_out_byte        = r_out_byte;
    assign o_status          = r_status;
    assign o_fill_count      = r_fill;

endmodule

[rtl/core/rdq_ctrl.sv]
// handshake controller: accepts beats, waits out ram reads, holds results
// depends on rdq_pkg
module rdq_ctrl (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [rdq_pkg::OP_W-1:0] i_opcode,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    input  rdq_pkg::t_dp_status      i_dp_status,
    output rdq_pkg::t_cmd            o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_SHOW = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   accept, needs_read;

    assign o_in_ready = (r_state == S_IDLE) || ((r_state == S_SHOW) && i_out_ready);
    assign accept     = i_in_valid && o_in_ready;
    assign needs_read = (rdq_pkg::t_opcode'(i_opcode) == rdq_pkg::OP_POP) && !i_dp_status.empty;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = needs_read ? S_READ : S_SHOW;
                end
            end
            S_READ: begin
                n_state = S_SHOW;
            end
            S_SHOW: begin
                if (accept) begin
                    n_state = needs_read ? S_READ : S_SHOW;
                end else if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd.exec    = accept;
    assign o_cmd.capture = (r_state == S_READ);
    assign o_out_valid   = (r_state == S_SHOW);

endmodule

[rtl/core/reversible_deque_core.sv]
// Byte deque with a reverse flag; one result beat for every input beat.
// Input channel: i_in_valid / o_in_ready with i_opcode and i_data_byte.
//   opcode toggle flips the reverse flag, push front / push back add a byte
//   at the logical end, pop removes the byte at the logical front.
// Output channel: o_out_valid / i_out_ready with o_out_byte, o_status and
//   o_fill_count (bytes stored after the beat).
// Result timing: toggle, push and a pop on an empty store show their result
//   in the cycle after acceptance; a pop that reads the character ram passes
//   through a read state first, since the ram's read data is registered.
// Throughput: one beat per cycle while no pop reads the ram and the output is
//   not stalled; a new beat is taken in the same cycle as the held result.
// Reset (synchronous, active low) empties the store and clears the reverse
//   flag; ram contents are left as they are and need no clearing pass.
// When the receiver stalls, the result holds and o_in_ready stays low.
// Depends on rdq_pkg, rdq_ctrl, rdq_datapath and rdq_ram.
module reversible_deque_core #(
    parameter int DEPTH = rdq_pkg::DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [rdq_pkg::OP_W-1:0]     i_opcode,
    input  logic [rdq_pkg::DATA_W-1:0]   i_data_byte,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [rdq_pkg::DATA_W-1:0]   o_out_byte,
    output logic [rdq_pkg::STAT_W-1:0]   o_status,
    output logic [rdq_pkg::FILL_W-1:0]   o_fill_count
);

    rdq_pkg::t_cmd       cmd;
    rdq_pkg::t_dp_status dp_status;

    rdq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_opcode    (i_opcode),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_dp_status (dp_status),
        .o_cmd       (cmd)
    );

    rdq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_opcode     (i_opcode),
        .i_data_byte  (i_data_byte),
        .o_dp_status  (dp_status),
        .o_out_byte   (o_out_byte),
        .o_status     (o_status),
        .o_fill_count (o_fill_count)
    );

endmodule

[rtl/core/rdq_checker.sv]
// port-level checks on the reversible deque, bound to the top level
// depends on rdq_pkg and assert_macros.svh
`include "assert_macros.svh"

module rdq_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_ready,
    input logic [rdq_pkg::OP_W-1:0]   i_opcode,
    input logic                       o_out_valid,
    input logic                       i_out_ready,
    input logic [rdq_pkg::DATA_W-1:0] o_out_byte,
    input logic [rdq_pkg::STAT_W-1:0] o_status,
    input logic [rdq_pkg::FILL_W-1:0] o_fill_count
);

    `ASSERT_NEXT(a_valid_holds, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)

    `ASSERT_NEXT(a_result_holds, i_clk, i_rst_n, o_out_valid && !i_out_ready,
        $stable(o_out_byte) && $stable(o_status) && $stable(o_fill_count))

    `ASSERT_IMPLIES(a_error_byte_zero, i_clk, i_rst_n,
        o_out_valid && (o_status != rdq_pkg::ST_OK), o_out_byte == '0)

    `ASSERT_IMPLIES(a_empty_pop_fill, i_clk, i_rst_n,
        o_out_valid && (o_status == rdq_pkg::ST_EMPTY), o_fill_count == '0)

    `ASSERT_NEXT(a_quick_result, i_clk, i_rst_n,
        i_in_valid && o_in_ready && (i_opcode != rdq_pkg::OP_POP), o_out_valid)

endmodule

bind reversible_deque_core rdq_checker u_rdq_checker (.*);
